// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: screen geometry defaults,
// field widths and control character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // default screen geometry and cell width
   localparam int DEF_COLS      = 40;
   localparam int DEF_ROWS      = 30;
   localparam int DEF_CELL_BITS = 16;

   // request and response field widths
   localparam int CELL_W   = 16;
   localparam int RROW_W   = 5;
   localparam int RCOL_W   = 6;
   localparam int CHAR_W   = 8;

   // request opcodes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_ENTER     = 8'h0d;

   // reset value of the printable threshold register
   localparam logic [CHAR_W-1:0] PRINTABLE_MIN_RST = 8'd20;

endpackage : tcw_pkg

`default_nettype wire

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (valid in the cycle after the address).
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1200,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : tcw_ram

`default_nettype wire

// ===== rtl/core/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console engine: a ROWS x COLS screen of character cells held in one
// RAM, a cursor, printable/backspace/enter handling and scroll-up.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen RAM to zero, one cell per cycle
// over all ROWS*COLS cells, and stalls requests until the sweep is done;
// csr writes are taken at any time. One request is worked at a time: a read
// waits in the read state for the RAM's registered read, and each result
// passes through the two-entry result queue (pending and output register).
// A put or enter that runs off the last row scrolls: the RAM is copied up
// one row a cell per cycle and the bottom row is then zeroed.
`default_nettype none

module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLS      = DEF_COLS,
   parameter int ROWS      = DEF_ROWS,
   parameter int CELL_BITS = DEF_CELL_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic [CELL_W-1:0] req_cell_value,
   input  wire logic [RROW_W-1:0] req_read_row,
   input  wire logic [RCOL_W-1:0] req_read_col,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [RROW_W-1:0] rsp_cursor_row,
   output logic      [RCOL_W-1:0] rsp_cursor_col,
   output logic      [CELL_W-1:0] rsp_read_data,
   output logic                   rsp_scrolled,
   // csr write channel
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CHAR_W-1:0] csr_wdata
);

   localparam int CELLS  = ROWS * COLS;
   localparam int AddrW  = $clog2(CELLS);
   localparam int RowW   = $clog2(ROWS);
   localparam int ColW   = $clog2(COLS);
   localparam int ExtW   = (CELL_BITS > CELL_W) ? CELL_BITS : CELL_W;

   localparam logic [AddrW-1:0] LAST_ADDR   = AddrW'(CELLS - 1);
   localparam logic [AddrW-1:0] BOTTOM_ADDR = AddrW'((ROWS - 1) * COLS);
   localparam logic [AddrW-1:0] ROW_STEP    = AddrW'(COLS);
   localparam logic [RowW-1:0]  LAST_ROW    = RowW'(ROWS - 1);
   localparam logic [ColW-1:0]  LAST_COL    = ColW'(COLS - 1);

   // state codes
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_BLANK  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [AddrW-1:0]    cnt_ff, cnt_in;
   logic [RowW-1:0]     cur_row_ff, cur_row_in;
   logic [ColW-1:0]     cur_col_ff, cur_col_in;
   logic [CHAR_W-1:0]   printable_min_ff;
   logic                rd_ok_ff, rd_ok_in;

   // copy pipeline during scroll: each write follows its read in the next cycle
   logic                copy_vld_ff;
   logic [AddrW-1:0]    copy_dst_ff;

   // pending result and output register
   logic                pend_vld_ff, pend_vld_in;
   logic [RowW-1:0]     pend_row_ff;
   logic [ColW-1:0]     pend_col_ff;
   logic [CELL_W-1:0]   pend_data_ff;
   logic                pend_scr_ff;
   logic                rsp_valid_ff;
   logic [RowW-1:0]     rsp_row_ff;
   logic [ColW-1:0]     rsp_col_ff;
   logic [CELL_W-1:0]   rsp_data_ff;
   logic                rsp_scr_ff;

   logic                res_vld;
   logic [CELL_W-1:0]   res_data;
   logic                res_scr;
   logic                move;

   // ram ports
   logic                mem_wr_en;
   logic [AddrW-1:0]    mem_wr_addr;
   logic [CELL_BITS-1:0] mem_wr_data;
   logic [AddrW-1:0]    mem_rd_addr;
   logic [CELL_BITS-1:0] mem_rd_data;
   logic [ExtW-1:0]     rd_ext;

   logic                accept;
   logic [CHAR_W-1:0]   ch;
   logic [AddrW-1:0]    cur_addr;
   logic [AddrW-1:0]    req_addr;
   logic                req_in_range;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !((state_ff == S_IDLE) && !pend_vld_ff);
   assign csr_ready = 1'b1;

   assign ch       = req_cell_value[CHAR_W-1:0];
   assign cur_addr = AddrW'(32'(cur_row_ff) * COLS + 32'(cur_col_ff));
   assign req_addr = AddrW'(32'(req_read_row) * COLS + 32'(req_read_col));
   assign req_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);
   assign rd_ext   = ExtW'(mem_rd_data);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      rd_ok_in    = rd_ok_ff;
      res_vld     = 1'b0;
      res_data    = '0;
      res_scr     = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cnt_ff;
      mem_wr_data = '0;
      mem_rd_addr = cnt_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            mem_rd_addr = req_addr;
            if (accept) begin
               if (req_op == OP_READ) begin
                  rd_ok_in = req_in_range;
                  state_in = S_READ;
               end else begin
                  // printable test comes first, so a low threshold wins
                  if (ch >= printable_min_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cur_addr;
                     mem_wr_data = CELL_BITS'(req_cell_value);
                     if (cur_col_ff == LAST_COL) begin
                        cur_col_in = '0;
                        if (cur_row_ff == LAST_ROW) begin
                           state_in = S_SCROLL;
                           cnt_in   = ROW_STEP;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end else if (ch == CH_BACKSPACE) begin
                     // one cell back, crossing rows, is simply address - 1
                     if (cur_addr != '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cur_addr - 1'b1;
                        if (cur_col_ff != '0) begin
                           cur_col_in = cur_col_ff - 1'b1;
                        end else begin
                           cur_row_in = cur_row_ff - 1'b1;
                           cur_col_in = LAST_COL;
                        end
                     end
                  end else if (ch == CH_ENTER) begin
                     cur_col_in = '0;
                     if (cur_row_ff == LAST_ROW) begin
                        state_in = S_SCROLL;
                        cnt_in   = ROW_STEP;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                  end
                  if (state_in != S_SCROLL) begin
                     res_vld = 1'b1;
                  end
               end
            end
         end
         S_READ: begin
            res_vld  = 1'b1;
            res_data = rd_ok_ff ? rd_ext[CELL_W-1:0] : '0;
            state_in = S_IDLE;
         end
         S_SCROLL: begin
            if (copy_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = copy_dst_ff;
               mem_wr_data = mem_rd_data;
            end
            if (cnt_ff == LAST_ADDR) begin
               state_in = S_BLANK;
               cnt_in   = BOTTOM_ADDR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_BLANK: begin
            mem_wr_en = 1'b1;
            if (copy_vld_ff) begin
               // last copy write drains before the bottom row is zeroed
               mem_wr_addr = copy_dst_ff;
               mem_wr_data = mem_rd_data;
            end else if (cnt_ff == LAST_ADDR) begin
               res_vld  = 1'b1;
               res_scr  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign move        = pend_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign pend_vld_in = res_vld || (pend_vld_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         cnt_ff           <= '0;
         cur_row_ff       <= '0;
         cur_col_ff       <= '0;
         printable_min_ff <= PRINTABLE_MIN_RST;
         rd_ok_ff         <= 1'b0;
         copy_vld_ff      <= 1'b0;
         pend_vld_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         rd_ok_ff    <= rd_ok_in;
         copy_vld_ff <= (state_ff == S_SCROLL);
         pend_vld_ff <= pend_vld_in;
         if (csr_valid && csr_ready) begin
            printable_min_ff <= csr_wdata;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff <= cnt_ff - ROW_STEP;
      if (res_vld) begin
         pend_row_ff  <= cur_row_in;
         pend_col_ff  <= cur_col_in;
         pend_data_ff <= res_data;
         pend_scr_ff  <= res_scr;
      end
      if (move) begin
         rsp_row_ff  <= pend_row_ff;
         rsp_col_ff  <= pend_col_ff;
         rsp_data_ff <= pend_data_ff;
         rsp_scr_ff  <= pend_scr_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = RROW_W'(rsp_row_ff);
   assign rsp_cursor_col = RCOL_W'(rsp_col_ff);
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   tcw_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_row_ff) < ROWS) && (32'(cur_col_ff) < COLS))
      else $error("cursor outside screen");

   a_scroll_keeps_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scr_ff) |-> (rsp_row_ff == LAST_ROW) && (rsp_col_ff == '0))
      else $error("scrolled response with cursor off the last row start");

   a_blank_in_bottom_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLANK) |-> (cnt_ff >= BOTTOM_ADDR))
      else $error("bottom row clear outside the bottom row");

   a_pend_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (pend_vld_ff && rsp_valid_ff && rsp_stall) |=> pend_vld_ff)
      else $error("pending response lost while output stalled");

   a_read_goes_to_read_state: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_READ)) |=> (state_ff == S_READ))
      else $error("read request did not enter read state");
`endif

endmodule : text_console_writer_top

`default_nettype wire
